### design/indexed_sorted_char_list_defines.svh
// Assertion macros used by the list controller (isc_ctrl).
`ifndef INDEXED_SORTED_CHAR_LIST_DEFINES_SVH
`define INDEXED_SORTED_CHAR_LIST_DEFINES_SVH

`ifndef SYNTHESIS

`define ISC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("isc assertion failed");

`define ISC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("isc assertion failed");

`else

`define ISC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define ISC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/isc_pkg.sv
package isc_pkg;

    localparam int DATA_W   = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_AT         = 3'd0,
        CMD_INSERT_AT       = 3'd1,
        CMD_INSERT_IN_ORDER = 3'd2,
        CMD_REMOVE_AT       = 3'd3,
        CMD_REPLACE_AT      = 3'd4,
        CMD_CLEAR           = 3'd5
    } t_command;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
        logic                     is_order;
    } t_cell_ctl;

    typedef struct packed {
        logic                     valid;
        logic                     found;
        logic signed [DATA_W-1:0] rd;
    } t_wave;

endpackage

### design/isc_cell.sv
module isc_cell
    import isc_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IDX      = 0,
    localparam int PW      = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [PW-1:0]            i_at,
    input  logic [PW-1:0]            i_count,
    input  logic signed [DATA_W-1:0] i_left_data,
    input  logic signed [DATA_W-1:0] i_right_data,
    output logic signed [DATA_W-1:0] o_data,
    input  t_wave                    i_wave,
    input  logic [PW-1:0]            i_wave_pos,
    output t_wave                    o_wave,
    output logic [PW-1:0]            o_wave_pos
);

    localparam logic [PW-1:0] IDX_W = PW'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    t_wave                    r_wave;
    t_wave                    n_wave;
    logic [PW-1:0]            r_wave_pos;
    logic [PW-1:0]            n_wave_pos;
    logic                     w_gt;

    assign w_gt = (IDX_W < i_count) && ($signed(r_data) > $signed(i_ctl.value));

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_SHIFT_UP: begin
                if (IDX_W > i_at) begin
                    n_data = i_left_data;
                end else if (IDX_W == i_at) begin
                    n_data = i_ctl.value;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (IDX_W >= i_at) begin
                    n_data = i_right_data;
                end
            end
            CELL_WRITE: begin
                if (IDX_W == i_at) begin
                    n_data = i_ctl.value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_comb begin
        n_wave.valid = i_wave.valid;
        n_wave.found = i_wave.found | (i_ctl.is_order & w_gt);
        n_wave.rd    = (!i_ctl.is_order && (IDX_W == i_at)) ? r_data : i_wave.rd;
        n_wave_pos   = (i_ctl.is_order && w_gt && !i_wave.found) ? IDX_W : i_wave_pos;
    end

    always_ff @(posedge i_clk) begin
        r_data       <= n_data;
        r_wave.found <= n_wave.found;
        r_wave.rd    <= n_wave.rd;
        r_wave_pos   <= n_wave_pos;
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= n_wave.valid;
        end
    end

    assign o_data     = r_data;
    assign o_wave     = r_wave;
    assign o_wave_pos = r_wave_pos;

endmodule

### design/isc_ctrl.sv
`include "indexed_sorted_char_list_defines.svh"

module isc_ctrl
    import isc_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int PW      = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [PW-1:0]            i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_busy,
    output t_cell_ctl                o_ctl,
    output logic [PW-1:0]            o_at,
    output logic [PW-1:0]            o_count,
    output t_wave                    o_wave,
    output logic [PW-1:0]            o_wave_pos,
    input  t_wave                    i_wave,
    input  logic [PW-1:0]            i_wave_pos,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [DATA_W-1:0] o_read_byte,
    output logic [PW-1:0]            o_used_position,
    output logic [PW-1:0]            o_res_count,
    output logic                     o_empty_res
);

    localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

    t_state                   r_state;
    t_state                   n_state;
    t_command                 r_cmd;
    logic [PW-1:0]            r_pos;
    logic signed [DATA_W-1:0] r_val;
    logic [PW-1:0]            r_count;
    logic [PW-1:0]            n_count;
    logic                     r_valid;
    logic [STATUS_W-1:0]      r_status;
    logic signed [DATA_W-1:0] r_rd;
    logic [PW-1:0]            r_used;
    logic [PW-1:0]            r_res_count;

    logic                     w_need_scan;
    logic                     w_launch;
    logic                     w_fire;
    logic [STATUS_W-1:0]      w_status;
    logic signed [DATA_W-1:0] w_rd;
    logic [PW-1:0]            w_used;

    assign w_need_scan = ((r_cmd == CMD_READ_AT) && (r_pos < r_count)) ||
                         ((r_cmd == CMD_INSERT_IN_ORDER) && (r_count != CAP_W));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = w_need_scan ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (i_wave.valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl.op       = CELL_HOLD;
        o_ctl.value    = r_val;
        o_ctl.is_order = (r_cmd == CMD_INSERT_IN_ORDER);
        o_at           = r_pos;
        w_launch       = 1'b0;
        w_fire         = 1'b0;
        w_status       = STATUS_OK;
        w_rd           = '0;
        w_used         = '0;
        n_count        = r_count;
        unique case (r_state)
            S_DECIDE: begin
                unique case (r_cmd)
                    CMD_READ_AT: begin
                        if (r_pos < r_count) begin
                            w_launch = 1'b1;
                        end else begin
                            w_fire   = 1'b1;
                            w_status = STATUS_RANGE;
                        end
                    end
                    CMD_INSERT_AT: begin
                        w_fire = 1'b1;
                        if (r_pos > r_count) begin
                            w_status = STATUS_RANGE;
                        end else if (r_count == CAP_W) begin
                            w_status = STATUS_FULL;
                        end else begin
                            o_ctl.op = CELL_SHIFT_UP;
                            w_used   = r_pos;
                            n_count  = r_count + PW'(1);
                        end
                    end
                    CMD_INSERT_IN_ORDER: begin
                        if (r_count == CAP_W) begin
                            w_fire   = 1'b1;
                            w_status = STATUS_FULL;
                        end else begin
                            w_launch = 1'b1;
                        end
                    end
                    CMD_REMOVE_AT: begin
                        w_fire = 1'b1;
                        if (r_pos < r_count) begin
                            o_ctl.op = CELL_SHIFT_DOWN;
                            w_used   = r_pos;
                            n_count  = r_count - PW'(1);
                        end else begin
                            w_status = STATUS_RANGE;
                        end
                    end
                    CMD_REPLACE_AT: begin
                        w_fire = 1'b1;
                        if (r_pos < r_count) begin
                            o_ctl.op = CELL_WRITE;
                            w_used   = r_pos;
                        end else begin
                            w_status = STATUS_RANGE;
                        end
                    end
                    CMD_CLEAR: begin
                        w_fire  = 1'b1;
                        n_count = '0;
                    end
                    default: begin
                        w_fire = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_wave.valid) begin
                    w_fire = 1'b1;
                    if (r_cmd == CMD_INSERT_IN_ORDER) begin
                        o_ctl.op = CELL_SHIFT_UP;
                        o_at     = i_wave_pos;
                        w_used   = i_wave_pos;
                        n_count  = r_count + PW'(1);
                    end else begin
                        w_rd   = i_wave.rd;
                        w_used = r_pos;
                    end
                end
            end
            default: begin
                w_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_cmd <= t_command'(i_command);
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (w_fire) begin
            r_status    <= w_status;
            r_rd        <= w_rd;
            r_used      <= w_used;
            r_res_count <= n_count;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_count         = r_count;
    assign o_wave.valid    = w_launch;
    assign o_wave.found    = 1'b0;
    assign o_wave.rd       = '0;
    assign o_wave_pos      = r_count;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_read_byte     = r_rd;
    assign o_used_position = r_used;
    assign o_res_count     = r_res_count;
    assign o_empty_res     = (r_res_count == '0);

    `ISC_ASSERT_IMP(a_count_in_bounds, i_clk, i_rst_n, 1'b1, r_count <= CAP_W)
    `ISC_ASSERT_IMP(a_wave_only_in_scan, i_clk, i_rst_n, i_wave.valid, r_state == S_SCAN)
    `ISC_ASSERT_IMP(a_full_means_full, i_clk, i_rst_n,
        o_valid && (o_status == STATUS_FULL), o_res_count == CAP_W)
    `ISC_ASSERT_NXT(a_accept_sets_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)

endmodule

### design/indexed_sorted_char_list.sv
// Fixed-capacity list of signed bytes held in a row of cells, one entry per cell.
// A command is accepted when start is high and busy is low. Insert at an index,
// remove, replace, clear and every rejected command pass only the DECIDE state
// between accept and the next possible accept; read_at and insert_in_order also
// pass SCAN, as their lookup travels down the cell row one cell per clock before
// the result is given or the list is updated. Exactly one result follows each
// transaction: it is shown for a single cycle with o_valid high, starting at the
// same clock edge at which busy falls, and must be taken then, since the receiver
// cannot stall the block. Entries are not cleared at reset; only the count is.
module indexed_sorted_char_list
    import isc_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int PW      = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [PW-1:0]            i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [DATA_W-1:0] o_read_byte,
    output logic [PW-1:0]            o_used_position,
    output logic [PW-1:0]            o_count,
    output logic                     o_empty_res
);

    t_cell_ctl                w_ctl;
    logic [PW-1:0]            w_at;
    logic [PW-1:0]            w_cell_count;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    t_wave                    w_wave [CAPACITY+1];
    logic [PW-1:0]            w_wave_pos [CAPACITY+1];

    isc_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_command),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_busy         (busy),
        .o_ctl          (w_ctl),
        .o_at           (w_at),
        .o_count        (w_cell_count),
        .o_wave         (w_wave[0]),
        .o_wave_pos     (w_wave_pos[0]),
        .i_wave         (w_wave[CAPACITY]),
        .i_wave_pos     (w_wave_pos[CAPACITY]),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_read_byte    (o_read_byte),
        .o_used_position(o_used_position),
        .o_res_count    (o_count),
        .o_empty_res    (o_empty_res)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_ctl.value;
        end else begin : g_mid_left
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_right
            assign w_right = w_data[g+1];
        end

        isc_cell #(
            .CAPACITY(CAPACITY),
            .IDX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_at        (w_at),
            .i_count     (w_cell_count),
            .i_left_data (w_left),
            .i_right_data(w_right),
            .o_data      (w_data[g]),
            .i_wave      (w_wave[g]),
            .i_wave_pos  (w_wave_pos[g]),
            .o_wave      (w_wave[g+1]),
            .o_wave_pos  (w_wave_pos[g+1])
        );
    end

endmodule
